@@ sv/button_press_double_hold_detector_assert.svh @@
// Assertion macros used by the button detector checker
`ifndef BUTTON_PRESS_DOUBLE_HOLD_DETECTOR_ASSERT_SVH
`define BUTTON_PRESS_DOUBLE_HOLD_DETECTOR_ASSERT_SVH

// Same-cycle implication, ignored while reset is low
`define BPDH_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, ignored while reset is low
`define BPDH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also covers reset
`define BPDH_ASSERT_NEXT_ANY(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/bpdh_pkg.sv @@
// Package: types, event codes and register map of the button detector
`timescale 1ns / 1ps
package bpdh_pkg;

  localparam int unsigned CntW  = 8;
  localparam int unsigned EvW   = 2;
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  localparam logic [EvW-1:0] EV_NONE   = 2'd0;
  localparam logic [EvW-1:0] EV_SINGLE = 2'd1;
  localparam logic [EvW-1:0] EV_DOUBLE = 2'd2;
  localparam logic [EvW-1:0] EV_HOLD   = 2'd3;

  localparam logic [1:0] REG_ACTIVE_LEVEL = 2'd0;
  localparam logic [1:0] REG_PRESS_TICKS  = 2'd1;
  localparam logic [1:0] REG_GAP_TICKS    = 2'd2;
  localparam logic [1:0] REG_HOLD_TICKS   = 2'd3;

  localparam logic [CntW-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic            active_level;
    logic [CntW-1:0] press_ticks;
    logic [CntW-1:0] double_gap_ticks;
    logic [CntW-1:0] hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic [CntW-1:0] active_count;
    logic [CntW-1:0] idle_count;
    logic [CntW-1:0] count_snapshot;
    logic            hold_seen;
  } state_t;

endpackage

@@ sv/button_press_double_hold_detector.sv @@
// Top level of the button press, double press and hold detector
`timescale 1ns / 1ps
//
//  channel   direction  handshake                    payload
//  in        input      in_valid / in_ready          in_level (1 bit)
//  out       output     out_valid / out_ready        out_event_res (2 bits)
//  cfg       input      psel/penable/pwrite/pready   paddr, pwdata, prdata
//
//  One item per cycle sustained while the result side drains; an item passes
//  from acceptance through the input register, then the result register.
//  Detector state advances when an item moves from the input register into
//  the result register, so results follow input order.
//  rst_n (synchronous, active low) clears state and valids, resets config.
//  A stalled result holds the result register; the input register holds its
//  item and in_ready drops only while both registers are full and stalled.
module button_press_double_hold_detector (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_level,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bpdh_pkg::EvW-1:0]       out_event_res,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bpdh_pkg::AddrW-1:0]     paddr,
  input  logic [bpdh_pkg::DataW-1:0]     pwdata,
  output logic [bpdh_pkg::DataW-1:0]     prdata,
  output logic                           pready
);

  // configuration registers
  bpdh_pkg::cfg_t   cfg_r;
  logic             cfg_wr;
  logic [1:0]       cfg_idx;

  // input register
  logic             s0_valid_r;
  logic             s0_level_r;

  // detector state and result register
  bpdh_pkg::state_t           st_r;
  bpdh_pkg::state_t           st_nxt;
  logic [bpdh_pkg::EvW-1:0]   event_nxt;
  logic                       out_valid_r;
  logic [bpdh_pkg::EvW-1:0]   event_r;

  logic advance;
  logic s0_load;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // read back the selected register, zero extended
  always_comb begin
    case (cfg_idx)
      bpdh_pkg::REG_ACTIVE_LEVEL: prdata = {31'd0, cfg_r.active_level};
      bpdh_pkg::REG_PRESS_TICKS:  prdata = {24'd0, cfg_r.press_ticks};
      bpdh_pkg::REG_GAP_TICKS:    prdata = {24'd0, cfg_r.double_gap_ticks};
      bpdh_pkg::REG_HOLD_TICKS:   prdata = {24'd0, cfg_r.hold_ticks};
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_level     <= 1'b0;
      cfg_r.press_ticks      <= 8'd3;
      cfg_r.double_gap_ticks <= 8'd20;
      cfg_r.hold_ticks       <= 8'd100;
    end else if (cfg_wr) begin
      case (cfg_idx)
        bpdh_pkg::REG_ACTIVE_LEVEL: cfg_r.active_level     <= pwdata[0];
        bpdh_pkg::REG_PRESS_TICKS:  cfg_r.press_ticks      <= pwdata[7:0];
        bpdh_pkg::REG_GAP_TICKS:    cfg_r.double_gap_ticks <= pwdata[7:0];
        bpdh_pkg::REG_HOLD_TICKS:   cfg_r.hold_ticks       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // advance the pipe whenever the result register is free or being drained
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s0_valid_r || advance;
  assign s0_load  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ready) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_load) begin
      s0_level_r <= in_level;
    end
  end

  bpdh_step u_step (
    .cfg       (cfg_r),
    .st        (st_r),
    .level     (s0_level_r),
    .st_nxt    (st_nxt),
    .event_nxt (event_nxt)
  );

  // commit state only when the item actually moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s0_valid_r;
      if (s0_valid_r) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s0_valid_r) begin
      event_r <= event_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_event_res = event_r;

endmodule

@@ sv/bpdh_step.sv @@
// Next-state and event logic for one sampled button level
`timescale 1ns / 1ps
module bpdh_step (
  input  bpdh_pkg::cfg_t             cfg,
  input  bpdh_pkg::state_t           st,
  input  logic                       level,
  output bpdh_pkg::state_t           st_nxt,
  output logic [bpdh_pkg::EvW-1:0]   event_nxt
);

  logic [bpdh_pkg::CntW-1:0] ac_inc;
  logic [bpdh_pkg::CntW-1:0] ic_inc;

  // saturating increments
  assign ac_inc = (st.active_count == bpdh_pkg::CNT_MAX) ? st.active_count
                                                         : st.active_count + 1'b1;
  assign ic_inc = (st.idle_count == bpdh_pkg::CNT_MAX) ? st.idle_count
                                                       : st.idle_count + 1'b1;

  always_comb begin
    st_nxt    = st;
    event_nxt = bpdh_pkg::EV_NONE;
    if (level == cfg.active_level) begin
      st_nxt.count_snapshot = '0;
      if (ac_inc >= cfg.hold_ticks) begin
        st_nxt.hold_seen    = 1'b1;
        st_nxt.idle_count   = '0;
        st_nxt.active_count = '0;
        event_nxt           = bpdh_pkg::EV_HOLD;
      end else begin
        st_nxt.active_count = ac_inc;
      end
    end else if ((st.active_count >= cfg.press_ticks) && !st.hold_seen) begin
      if (ic_inc >= cfg.double_gap_ticks) begin
        st_nxt.active_count = '0;
        st_nxt.idle_count   = '0;
        event_nxt           = bpdh_pkg::EV_SINGLE;
      end else if ((ic_inc > 8'd1) && (st.count_snapshot != st.active_count)) begin
        st_nxt.active_count = '0;
        st_nxt.idle_count   = '0;
        event_nxt           = bpdh_pkg::EV_DOUBLE;
      end else begin
        st_nxt.idle_count = ic_inc;
      end
      st_nxt.count_snapshot = st_nxt.active_count;
    end else begin
      st_nxt = '0;
    end
  end

endmodule

@@ sv/bpdh_checker.sv @@
// Port-level checker for the button detector and its bind
`timescale 1ns / 1ps
`include "button_press_double_hold_detector_assert.svh"
module bpdh_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [bpdh_pkg::EvW-1:0]     out_event_res,
  input logic                         pready
);

  // an empty result side never blocks the input
  `BPDH_ASSERT_IMPLY(a_free_out_ready, !out_valid, in_ready)
  // a draining result side never blocks the input
  `BPDH_ASSERT_IMPLY(a_drain_ready, out_ready, in_ready)
  // a stalled result holds
  `BPDH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_event_res))
  // reset empties the result side
  `BPDH_ASSERT_NEXT_ANY(a_rst_empty, !rst_n, !out_valid)
  // configuration port never waits
  `BPDH_ASSERT_IMPLY(a_pready, in_valid || !in_valid, pready)

endmodule

bind button_press_double_hold_detector bpdh_checker u_bpdh_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_event_res (out_event_res),
  .pready        (pready)
);

@@ dv/tb_button_press_double_hold_detector.sv @@
// Testbench for the button press, double press and hold detector
`timescale 1ns / 1ps
module tb_button_press_double_hold_detector;

  localparam int MaxReported = 10;

  // Clock, reset and block ports; every input starts at a known value
  logic                          clk            = 1'b0;
  logic                          rst_n          = 1'b0;
  logic                          in_valid       = 1'b0;
  logic                          in_ready;
  logic                          in_level       = 1'b0;
  logic                          out_valid;
  logic                          out_ready      = 1'b0;
  logic [bpdh_pkg::EvW-1:0]      out_event_res;
  logic                          psel           = 1'b0;
  logic                          penable        = 1'b0;
  logic                          pwrite         = 1'b0;
  logic [bpdh_pkg::AddrW-1:0]    paddr          = '0;
  logic [bpdh_pkg::DataW-1:0]    pwdata         = '0;
  logic [bpdh_pkg::DataW-1:0]    prdata;
  logic                          pready;

  // Detector copy kept by the testbench: register settings and press state
  bpdh_pkg::cfg_t                press_cfg;
  bpdh_pkg::state_t              press_state;
  // Event codes still owed by the block, oldest first
  logic [bpdh_pkg::EvW-1:0]      pending_events[$];

  int               mismatches     = 0;
  int               levels_sent    = 0;
  int               sender_idle_pct = 0;
  int               receiver_stall_pct = 0;

  // 8 ns period: low half, then high half
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  button_press_double_hold_detector dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_level      (in_level),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_event_res (out_event_res),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Log the first few mismatches in full, count the rest silently
  task automatic note_mismatch(input string what, input logic [bpdh_pkg::DataW-1:0] want,
                               input logic [bpdh_pkg::DataW-1:0] got);
    mismatches++;
    if (mismatches <= MaxReported)
      $display("mismatch (%s): expected %0d, got %0d at %0t", what, want, got, $realtime);
  endtask

  // Advance the detector copy by one sampled level and return the event it yields
  function automatic logic [bpdh_pkg::EvW-1:0] predict_event(input logic lvl);
    logic [bpdh_pkg::EvW-1:0] ev;
    ev = bpdh_pkg::EV_NONE;
    if (lvl == press_cfg.active_level) begin
      // Pressed tick: count it, forget the idle snapshot, fire a hold at the limit
      if (press_state.active_count != bpdh_pkg::CNT_MAX)
        press_state.active_count = press_state.active_count + 1'b1;
      press_state.count_snapshot = '0;
      if (press_state.active_count >= press_cfg.hold_ticks) begin
        press_state.hold_seen    = 1'b1;
        press_state.idle_count   = '0;
        press_state.active_count = '0;
        ev = bpdh_pkg::EV_HOLD;
      end
    end else if (press_state.active_count >= press_cfg.press_ticks &&
                 !press_state.hold_seen) begin
      // Released after a valid press: time the gap, look for a second press
      if (press_state.idle_count != bpdh_pkg::CNT_MAX)
        press_state.idle_count = press_state.idle_count + 1'b1;
      if (press_state.idle_count >= press_cfg.double_gap_ticks) begin
        press_state.active_count = '0;
        press_state.idle_count   = '0;
        ev = bpdh_pkg::EV_SINGLE;
      end else if (press_state.idle_count > 1 &&
                   press_state.count_snapshot != press_state.active_count) begin
        press_state.active_count = '0;
        press_state.idle_count   = '0;
        ev = bpdh_pkg::EV_DOUBLE;
      end
      press_state.count_snapshot = press_state.active_count;
    end else begin
      // Short press, release after a hold, or plain idle: drop everything
      press_state = '0;
    end
    return ev;
  endfunction

  // Receiver: stall at random per cycle, changes on the falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Sample both channels at the rising edge; check the result before logging
  // the new item so a same-edge item can never satisfy its own check
  always @(posedge clk) begin
    logic [bpdh_pkg::EvW-1:0] want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_events.size() == 0) begin
          note_mismatch("event with none pending", '0,
                        bpdh_pkg::DataW'(out_event_res));
        end else begin
          want = pending_events.pop_front();
          if (out_event_res !== want)
            note_mismatch("event_res", bpdh_pkg::DataW'(want),
                          bpdh_pkg::DataW'(out_event_res));
        end
      end
      if (in_valid && in_ready)
        pending_events.push_back(predict_event(in_level));
    end
  end

  // Send one sampled level; idle first if the sender phase asks for gaps.
  // Called and returning at a falling edge.
  task automatic send_level(input logic lvl);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_level <= lvl;
    do @(posedge clk); while (!in_ready);
    levels_sent++;
    @(negedge clk);
  endtask

  // Hold the button pressed (or released) for n ticks under the current polarity
  task automatic drive_ticks(input bit pressed, input int n);
    repeat (n) send_level(pressed ? press_cfg.active_level : ~press_cfg.active_level);
  endtask

  // Stop sending and wait for every owed event, then let the pipe settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_read(input logic [1:0] idx, input logic [bpdh_pkg::DataW-1:0] want);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      note_mismatch("register readback", want, prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write one register, mirror it in the detector copy, then read it back
  task automatic cfg_write(input logic [1:0] idx, input logic [bpdh_pkg::DataW-1:0] value);
    logic [bpdh_pkg::DataW-1:0] stored;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      bpdh_pkg::REG_ACTIVE_LEVEL:
        press_cfg.active_level     = value[0];
      bpdh_pkg::REG_PRESS_TICKS:
        press_cfg.press_ticks      = value[bpdh_pkg::CntW-1:0];
      bpdh_pkg::REG_GAP_TICKS:
        press_cfg.double_gap_ticks = value[bpdh_pkg::CntW-1:0];
      bpdh_pkg::REG_HOLD_TICKS:
        press_cfg.hold_ticks       = value[bpdh_pkg::CntW-1:0];
      default: ;
    endcase
    stored = (idx == bpdh_pkg::REG_ACTIVE_LEVEL) ? {31'd0, value[0]}
                                                 : {24'd0, value[bpdh_pkg::CntW-1:0]};
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    cfg_read(idx, stored);
  endtask

  // Reprogram all four registers once the block has gone quiet
  task automatic set_config(input logic lvl, input int press, input int gap, input int hold);
    wait_drained();
    cfg_write(bpdh_pkg::REG_ACTIVE_LEVEL, bpdh_pkg::DataW'(lvl));
    cfg_write(bpdh_pkg::REG_PRESS_TICKS, press);
    cfg_write(bpdh_pkg::REG_GAP_TICKS, gap);
    cfg_write(bpdh_pkg::REG_HOLD_TICKS, hold);
  endtask

  task automatic test_register_defaults();
    cfg_read(bpdh_pkg::REG_ACTIVE_LEVEL, 32'd0);
    cfg_read(bpdh_pkg::REG_PRESS_TICKS, 32'd3);
    cfg_read(bpdh_pkg::REG_GAP_TICKS, 32'd20);
    cfg_read(bpdh_pkg::REG_HOLD_TICKS, 32'd100);
  endtask

  // Press long enough, then stay released for the whole gap
  task automatic test_single_press();
    set_config(1'b1, 2, 3, 4);
    drive_ticks(1, 2);
    drive_ticks(0, 3);
  endtask

  // Second press lands inside the gap and is released again
  task automatic test_double_press();
    drive_ticks(1, 2);
    drive_ticks(0, 1);
    drive_ticks(1, 1);
    drive_ticks(0, 2);
  endtask

  // Reach the hold count, then release: the release clears the press
  task automatic test_hold();
    drive_ticks(1, 4);
    drive_ticks(0, 1);
  endtask

  task automatic test_short_press();
    drive_ticks(1, 1);
    drive_ticks(0, 1);
  endtask

  // Zero hold count: every pressed tick is a hold; zero press and gap counts:
  // a bare idle tick already reports a single press
  task automatic test_zero_counts();
    set_config(1'b0, 0, 0, 0);
    drive_ticks(1, 1);
    drive_ticks(0, 2);
  endtask

  // Gestures shaped around the current counts: mostly real presses with gaps
  // around the double-press window, some holds, some short taps and noise
  task automatic run_gestures(input int n);
    int first;
    int p, g, h, r;
    first = levels_sent;
    p = press_cfg.press_ticks;
    g = press_cfg.double_gap_ticks;
    h = press_cfg.hold_ticks;
    while (levels_sent - first < n) begin
      r = $urandom_range(9);
      if (r < 2)       drive_ticks(1, $urandom_range(0, p));
      else if (r < 7)  drive_ticks(1, $urandom_range(p, p + 4));
      else if (r < 9)  drive_ticks(1, $urandom_range(h, h + 3));
      else             repeat ($urandom_range(1, 8)) send_level(1'($urandom_range(1)));
      r = $urandom_range(9);
      if (r < 4)       drive_ticks(0, $urandom_range(1, (g > 1) ? g : 1));
      else if (r < 8)  drive_ticks(0, $urandom_range(g, g + 3));
      else             drive_ticks(0, $urandom_range(0, 2));
      // Now and then let everything drain before the next gesture
      if ($urandom_range(39) == 0) wait_drained();
    end
  endtask

  // One idling phase: a random setting with short counts, then an extreme one
  task automatic test_random_gestures(input int phase);
    case (phase)
      0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      1: begin sender_idle_pct = 61; receiver_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  receiver_stall_pct = 61; end
      default: begin sender_idle_pct = 29; receiver_stall_pct = 29; end
    endcase
    set_config(1'($urandom_range(1)), $urandom_range(0, 6), $urandom_range(0, 12),
               $urandom_range(0, 40));
    run_gestures(90);
    case (phase)
      0: set_config(1'b0, 0, 0, 0);
      1: set_config(1'b1, 255, 255, 255);
      2: set_config(1'b0, 0, 255, 7);
      default: set_config(1'b1, 1, 0, 255);
    endcase
    run_gestures(35);
  endtask

  initial begin
    press_cfg   = '{active_level: 1'b0, press_ticks: 8'd3, double_gap_ticks: 8'd20,
                    hold_ticks: 8'd100};
    press_state = '0;
    // Hold reset from the start, release it on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_register_defaults();
    test_single_press();
    test_double_press();
    test_hold();
    test_short_press();
    test_zero_counts();
    for (int phase = 0; phase < 4; phase++)
      test_random_gestures(phase);

    wait_drained();
    if (mismatches == 0 && pending_events.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ button_press_double_hold_detector.f @@
+incdir+sv
sv/bpdh_pkg.sv
sv/bpdh_step.sv
sv/button_press_double_hold_detector.sv
sv/bpdh_checker.sv
dv/tb_button_press_double_hold_detector.sv
